>>> hdl/lzw_pkg.sv
// Shared types and constants for the LZW byte compressor.
// Used by lzw_byte_compressor, the port checker and the testbench; no dependencies.
`default_nettype none
package lzw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [11:0] code_word;
    logic        last_of_item;
    logic        end_of_message;
  } out_req_t;

  localparam int unsigned EPOCH_BITS = 8;
  localparam int unsigned FIRST_CODE = 256;
  localparam logic [31:0] HASH_MULT  = 32'd40503;

endpackage
`default_nettype wire

>>> hdl/lzw_dict_ram.sv
// Single-port dictionary memory with a registered read port.
// Depends on nothing; the width and the depth come from the top level.
`default_nettype none
module lzw_dict_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

>>> hdl/lzw_byte_compressor.sv
// Top level of the LZW byte compressor: control sequencer, hashing and probing.
// Depends on lzw_pkg and lzw_dict_ram.
`default_nettype none
// Usage
// One request on the input channel carries one raw byte and a flag marking the
// last byte of a message. Each request yields zero, one or two code requests on
// the output channel; last_of_item marks the final code caused by a byte and
// end_of_message marks the final code of the message.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low at a rising edge.
// Sequencing: a byte that only starts a string is handled in S_IDLE as it is
// accepted. Any other byte then passes through S_HASH, S_CMP, which probes one
// dictionary slot per cycle (linear probing in the single-port memory), and
// S_MISS when a code is emitted. The final byte adds S_FINAL for the closing
// code.
// The output register holds one code; while the receiver stalls, the block keeps
// accepting bytes until it needs to emit another code, and then waits.
// The dictionary is invalidated by an epoch mark at the end of each message.
// After reset, and whenever the epoch counter wraps, a clearing pass writes every
// slot; no byte is accepted during it.
// TABLE_DEPTH must be a power of two.
module lzw_byte_compressor #(
  parameter int unsigned CODE_BITS   = 12,
  parameter int unsigned TABLE_DEPTH = 8192
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lzw_pkg::in_req_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lzw_pkg::out_req_t      out_data_o
);

  localparam int unsigned IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_BITS = CODE_BITS + 8;
  localparam int unsigned EB       = lzw_pkg::EPOCH_BITS;
  localparam int unsigned WIDTH    = EB + KEY_BITS + CODE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_MISS  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CODE_BITS-1:0]  prefix_q, prefix_d;
  logic                  present_q, present_d;
  logic [CODE_BITS:0]    next_free_q, next_free_d;
  logic [EB-1:0]         epoch_q, epoch_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [IDX_BITS-1:0]   probes_q, probes_d;
  logic                  slot_ok_q, slot_ok_d;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic [31:0]           hm_q;
  logic                  out_valid_q, out_valid_d;
  lzw_pkg::out_req_t     out_q, out_d;

  logic                  accept;
  logic                  out_free;
  logic [KEY_BITS-1:0]   key;
  logic [7:0]            hash_byte;
  logic [31:0]           key32;
  logic [31:0]           h1;
  logic [31:0]           h2;
  logic                  we;
  logic [IDX_BITS-1:0]   addr;
  logic [WIDTH-1:0]      wdata;
  logic [WIDTH-1:0]      rdata;
  logic [EB-1:0]         rd_epoch;
  logic [KEY_BITS-1:0]   rd_key;
  logic [CODE_BITS-1:0]  rd_code;
  logic [CODE_BITS+11:0] prefix_wide;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The key is the current string code beside the new byte.
  assign key         = {prefix_q, byte_q};
  // The hash is started in the accepting cycle from the incoming byte, so the
  // product is already registered when S_HASH forms the slot index.
  assign hash_byte   = accept ? in_data_i.data_byte : byte_q;
  assign key32       = 32'({prefix_q, hash_byte});
  assign h1          = key32 ^ (key32 >> 11);
  assign h2          = hm_q ^ (hm_q >> 15);
  assign prefix_wide = {12'd0, prefix_q};

  assign {rd_epoch, rd_key, rd_code} = rdata;

  lzw_dict_ram #(
    .WIDTH (WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    prefix_d    = prefix_q;
    present_d   = present_q;
    next_free_d = next_free_q;
    epoch_d     = epoch_q;
    idx_d       = idx_q;
    probes_d    = probes_q;
    slot_ok_d   = slot_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    addr        = idx_q;
    wdata       = {epoch_q, key, next_free_q[CODE_BITS-1:0]};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!present_q) begin
            prefix_d  = CODE_BITS'(in_data_i.data_byte);
            present_d = 1'b1;
            if (in_data_i.last_byte) begin
              state_d = S_FINAL;
            end
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        idx_d    = h2[IDX_BITS-1:0];
        addr     = h2[IDX_BITS-1:0];
        probes_d = '0;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (rd_epoch != epoch_q) begin
          // An empty slot ends the probe; the pair is new and may go here.
          slot_ok_d = 1'b1;
          state_d   = S_MISS;
        end else if (rd_key == key) begin
          prefix_d = rd_code;
          state_d  = last_q ? S_FINAL : S_IDLE;
        end else if (probes_q == {IDX_BITS{1'b1}}) begin
          // Every slot was visited without a match or a free place.
          slot_ok_d = 1'b0;
          state_d   = S_MISS;
        end else begin
          probes_d = probes_q + 1'b1;
          idx_d    = idx_q + 1'b1;
          addr     = idx_q + 1'b1;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.code_word        = prefix_wide[11:0];
          out_d.last_of_item     = !last_q;
          out_d.end_of_message   = 1'b0;
          if (!next_free_q[CODE_BITS]) begin
            we          = slot_ok_q;
            next_free_d = next_free_q + 1'b1;
          end
          prefix_d = CODE_BITS'(byte_q);
          state_d  = last_q ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.code_word      = prefix_wide[11:0];
          out_d.last_of_item   = 1'b1;
          out_d.end_of_message = 1'b1;
          prefix_d             = '0;
          present_d            = 1'b0;
          next_free_d          = (CODE_BITS+1)'(lzw_pkg::FIRST_CODE);
          epoch_d              = epoch_q + 1'b1;
          if (epoch_q == {EB{1'b1}}) begin
            idx_d   = '0;
            state_d = S_CLEAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        // Epoch zero is never current, so these slots read as empty.
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == {IDX_BITS{1'b1}}) begin
          epoch_d = EB'(1);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      prefix_q    <= '0;
      present_q   <= 1'b0;
      next_free_q <= (CODE_BITS+1)'(lzw_pkg::FIRST_CODE);
      epoch_q     <= EB'(1);
      idx_q       <= '0;
      probes_q    <= '0;
      slot_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      present_q   <= present_d;
      next_free_q <= next_free_d;
      epoch_q     <= epoch_d;
      idx_q       <= idx_d;
      probes_q    <= probes_d;
      slot_ok_q   <= slot_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      byte_q <= in_data_i.data_byte;
      last_q <= in_data_i.last_byte;
    end
    hm_q <= h1 * lzw_pkg::HASH_MULT;
  end

endmodule
`default_nettype wire

>>> hdl/lzw_port_checker.sv
// Port-level checks for the LZW byte compressor, bound to its top level.
// Depends on lzw_pkg.
`default_nettype none
module lzw_port_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire lzw_pkg::in_req_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire lzw_pkg::out_req_t out_data_o
);

  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_message |-> out_data_o.last_of_item)
    else $error("end of message without last of item");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_byte |=> in_stall_o)
    else $error("last byte accepted without closing code work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output request changed");

endmodule

bind lzw_byte_compressor lzw_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for lzw_byte_compressor: byte messages in, LZW codes out.
// Depends on lzw_pkg and the RTL of the compressor; predicts codes with its own dictionary.
`default_nettype none

// Keeps an exact-match copy of the dictionary and a queue of codes still due.
class lzw_code_board;
  lzw_pkg::out_req_t codes_due[$];
  logic [11:0]       string_code;
  bit                string_held;
  int unsigned       free_code;
  int unsigned       known_pairs[int unsigned];
  int unsigned       mismatches;
  int unsigned       codes_seen;

  function new();
    mismatches = 0;
    codes_seen = 0;
    clear_dict();
  endfunction

  function void clear_dict();
    known_pairs.delete();
    string_code = '0;
    string_held = 1'b0;
    free_code   = lzw_pkg::FIRST_CODE;
  endfunction

  function void push_code(logic [11:0] code, bit item_end, bit msg_end);
    lzw_pkg::out_req_t c;
    c.code_word      = code;
    c.last_of_item   = item_end;
    c.end_of_message = msg_end;
    codes_due.push_back(c);
  endfunction

  // Called for every byte the compressor accepts.
  function void note_byte(lzw_pkg::in_req_t req);
    int unsigned pair;
    if (!string_held) begin
      string_code = {4'd0, req.data_byte};
      string_held = 1'b1;
    end else begin
      pair = 32'({string_code, req.data_byte});
      if (known_pairs.exists(pair)) begin
        string_code = known_pairs[pair][11:0];
      end else begin
        push_code(string_code, !req.last_byte, 1'b0);
        if (free_code < 4096) begin
          known_pairs[pair] = free_code;
          free_code++;
        end
        string_code = {4'd0, req.data_byte};
      end
    end
    if (req.last_byte) begin
      push_code(string_code, 1'b1, 1'b1);
      clear_dict();
    end
  endfunction

  function void check_code(lzw_pkg::out_req_t got);
    lzw_pkg::out_req_t want;
    codes_seen++;
    if (codes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected code %0d (last_of_item %0b, end_of_message %0b)",
                 got.code_word, got.last_of_item, got.end_of_message);
      return;
    end
    want = codes_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: code %0d/%0b/%0b, expected %0d/%0b/%0b",
                 got.code_word, got.last_of_item, got.end_of_message,
                 want.code_word, want.last_of_item, want.end_of_message);
    end
  endfunction

  function int unsigned pending();
    return codes_due.size();
  endfunction
endclass

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 40000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              out_stall_i = 1'b0;
  lzw_pkg::in_req_t  in_data_i   = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  lzw_pkg::out_req_t out_data_o;

  lzw_code_board board = new();

  // Control between the sender and the receiver processes.
  bit          hold_request = 1'b0;
  bit          sending_done = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned messages     = 0;

  lzw_byte_compressor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offers one byte and returns once the compressor has taken it. The valid
  // line is only lowered when a gap is wanted, so back-to-back requests never
  // see two assignments to it in one step.
  task automatic send_byte(input logic [7:0] value, input bit is_last, input bit gaps_on);
    int unsigned      gap;
    lzw_pkg::in_req_t req;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.data_byte = value;
    req.last_byte = is_last;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(req);
    bytes_sent++;
    if (is_last) messages++;
  endtask

  // A message of the given length; a narrow alphabet makes repeats, and so
  // dictionary hits, far more likely.
  task automatic send_message(input int unsigned len, input int unsigned span,
                              input bit gaps_on);
    logic [7:0] base;
    base = $urandom_range(255);
    for (int unsigned i = 0; i < len; i++)
      send_byte(base + 8'($urandom_range(span - 1)), i == len - 1, gaps_on);
  endtask

  // Hands the input back to idle, for a pause or once the sender has finished.
  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stall runs, with a long hold-off when the sender asks.
  initial begin : receiver
    int unsigned run_left;
    bit          stalling;
    run_left = 0;
    stalling = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        board.check_code(out_data_o);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        run_left = 0;
        stalling = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        // A quiet stretch every so often, where the receiver never stalls.
        stalling = ($urandom_range(9) < 3) && !sending_done;
        run_left = stalling ? pick_gap() : $urandom_range(30);
        out_stall_i <= stalling;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request. The
  // clearing pass after reset and at each epoch wrap is well within the limit.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: %0d cycles without a request, %0d codes still due",
               idle_cycles, board.pending());
      $display("lzw_byte_compressor verification failed");
      $finish;
    end
  end

  initial begin : sender
    int unsigned wait_cycles;
    int unsigned roll;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: one-byte messages at the byte extremes, the first of which
    // has to wait for the clearing pass, a repeating pattern that grows strings
    // through the dictionary, and two short messages that repeat a single byte.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++)
      send_byte((i % 2) ? 8'h41 : 8'h42, i == 8, 1'b0);
    for (int i = 0; i < 8; i++)
      send_byte(8'h55, i == 7, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b1, 1'b1);

    // Random messages, mostly short and repetitive, with some wide ones.
    while (bytes_sent < 1900) begin
      roll = $urandom_range(99);
      if (roll < 60)      send_message($urandom_range(12, 1), $urandom_range(4, 1), 1'b1);
      else if (roll < 85) send_message($urandom_range(12, 1), 256, 1'b1);
      else                send_message($urandom_range(80, 13), $urandom_range(16, 2), 1'b1);

      // Once: the receiver holds off while bytes keep coming in.
      if (messages == 60) begin
        hold_request = 1'b1;
        send_message(40, 3, 1'b0);
      end
      // Once: a pause until every code due has come out.
      if (messages == 90) begin
        release_input();
        while (board.pending() != 0) @(posedge clk_i);
      end
    end
    release_input();
    sending_done = 1'b1;

    wait_cycles = 0;
    while (board.pending() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages and checked %0d codes,", bytes_sent, messages,
             board.codes_seen);
    $display("including dictionary hits and misses, one-byte messages and a long hold-off.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("lzw_byte_compressor verification clean");
    end else begin
      $display("%0d mismatches, %0d codes never arrived", board.mismatches, board.pending());
      $display("lzw_byte_compressor verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
